// ===== rtl/cbt_pkg.sv =====
// Package for the delimited-text byte tokenizer.
// Holds the character codes, event kinds, register indexes and shared structs.
// No dependencies. Read first by every other file.
package cbt_pkg;

   // character codes with fixed meaning
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // configuration register map
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELIMITER  = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HAS_HEADER = 4'd1;
   localparam logic [7:0] DELIMITER_RESET = 8'd44;

   // token event kinds
   typedef enum logic [1:0] {
      KIND_CHAR      = 2'd0,
      KIND_FIELD     = 2'd1,
      KIND_FIELD_ROW = 2'd2,
      KIND_ROW       = 2'd3
   } kind_type;

   // tokenizer state flags
   typedef struct packed {
      logic in_quotes;
      logic quote_pending;
      logic cr_pending;
      logic field_has_chars;
      logic row_has_fields;
      logic in_first_row;
   } tok_state_type;

   localparam tok_state_type TOK_STATE_RESET = '{
      in_quotes:       1'b0,
      quote_pending:   1'b0,
      cr_pending:      1'b0,
      field_has_chars: 1'b0,
      row_has_fields:  1'b0,
      in_first_row:    1'b1
   };

   // one token event
   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic [7:0] out_char;
      logic     header_row;
   } tok_event_type;

endpackage

// ===== rtl/cbt_if.sv =====
// Handshake interfaces for the tokenizer: byte request, token response,
// and register write channel. Depends on cbt_pkg.
interface cbt_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] char_value;

   modport source (output valid, mode, char_value, input ready);
   modport sink   (input valid, mode, char_value, output ready);
endinterface

interface cbt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_char;
   logic       header_row;

   modport source (output valid, kind, out_char, header_row, input ready);
   modport sink   (input valid, kind, out_char, header_row, output ready);
endinterface

interface cbt_csr_if;
   logic                          valid;
   logic                          ready;
   logic [cbt_pkg::CSR_ADDR_W-1:0] index;
   logic [7:0]                    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/cbt_step.sv =====
// Next-state and event logic for one text byte or end-of-data marker.
// Purely combinational. Depends on cbt_pkg.
module cbt_step (
   input  cbt_pkg::tok_state_type state,
   input  logic                   mode,
   input  logic [7:0]             char_value,
   input  logic [7:0]             delimiter,
   input  logic                   has_header,
   output cbt_pkg::tok_state_type state_next,
   output cbt_pkg::tok_event_type event_out
);
   import cbt_pkg::*;

   logic plain;
   logic iq;

   always_comb begin
      state_next           = state;
      event_out.valid      = 1'b0;
      event_out.kind       = KIND_CHAR;
      event_out.out_char   = 8'd0;
      // header flag uses the row state before this byte
      event_out.header_row = has_header & state.in_first_row;
      plain                = 1'b1;
      iq                   = state.in_quotes;

      if (mode) begin
         // end of data: close the open field or row, then clear everything
         plain = 1'b0;
         if (state.field_has_chars) begin
            event_out.valid = 1'b1;
            event_out.kind  = KIND_FIELD_ROW;
         end else if (state.row_has_fields) begin
            event_out.valid = 1'b1;
            event_out.kind  = KIND_ROW;
         end
         state_next = TOK_STATE_RESET;
      end else if (state.quote_pending) begin
         // doubled quote is a literal, anything else closes quoting
         state_next.quote_pending = 1'b0;
         if (char_value == CH_QUOTE) begin
            plain                      = 1'b0;
            state_next.field_has_chars = 1'b1;
            event_out.valid            = 1'b1;
            event_out.out_char         = CH_QUOTE;
         end else begin
            iq                   = 1'b0;
            state_next.in_quotes = 1'b0;
         end
      end else if (state.cr_pending) begin
         // LF of CRLF is swallowed
         state_next.cr_pending = 1'b0;
         if (char_value == CH_LF) begin
            plain = 1'b0;
         end
      end

      // normal byte handling: quote, then delimiter, then line end
      if (plain) begin
         if (char_value == CH_QUOTE) begin
            if (iq) begin
               state_next.quote_pending = 1'b1;
            end else begin
               state_next.in_quotes = 1'b1;
            end
         end else if (!iq && char_value == delimiter) begin
            event_out.valid            = 1'b1;
            event_out.kind             = KIND_FIELD;
            state_next.field_has_chars = 1'b0;
            state_next.row_has_fields  = 1'b1;
         end else if (!iq && (char_value == CH_LF || char_value == CH_CR)) begin
            event_out.valid            = 1'b1;
            event_out.kind             = KIND_FIELD_ROW;
            state_next.field_has_chars = 1'b0;
            state_next.row_has_fields  = 1'b0;
            state_next.in_first_row    = 1'b0;
            state_next.cr_pending      = (char_value == CH_CR);
         end else begin
            event_out.valid            = 1'b1;
            event_out.out_char         = char_value;
            state_next.field_has_chars = 1'b1;
         end
      end
   end

endmodule

// ===== rtl/csv_byte_tokenizer_core.sv =====
// Top level of the delimited-text byte tokenizer.
// Depends on cbt_pkg, cbt_if.sv and cbt_step.
//
// Usage:
//   req_if  : one text byte (mode 0) or an end-of-data marker (mode 1) per
//             transfer. One transfer can be taken every clock cycle while the receiver keeps up.
//   rsp_if  : at most one token event per request: field character, field
//             end, field and row end, or row end only. Bytes that give no
//             event (quotes, LF after CR) produce no transfer.
//   csr_if  : register writes, index 0 = delimiter, 1 = has_header; other
//             indexes are ignored. Always ready; write only while idle.
// An event passes through the input register, then the result register,
// before it is presented on rsp_if. Throughput is one byte per cycle while
// the receiver does not stall, set by the combinational flag update
// between those two registers.
// Reset (synchronous, active high) empties both stages, clears the quote,
// CR and content flags, marks the first row, and sets delimiter to comma
// and has_header to 0. End of data clears the flags but keeps registers.
// When the receiver stalls, the result register holds its event and the
// input register fills; req_if.ready then drops until rsp_if.ready returns,
// while bytes that give no event still drain through.
module csv_byte_tokenizer_core (
   input logic       clock,
   input logic       reset,
   cbt_req_if.sink   req_if,
   cbt_rsp_if.source rsp_if,
   cbt_csr_if.sink   csr_if
);
   import cbt_pkg::*;

   // configuration registers
   logic [7:0] delimiter_ff;
   logic       has_header_ff;

   // input stage
   logic       in_valid_ff;
   logic       in_mode_ff;
   logic [7:0] in_char_ff;

   // tokenizer state
   tok_state_type state_ff;
   tok_state_type state_in;
   tok_event_type step_event;

   // result stage
   logic       out_valid_ff;
   kind_type   out_kind_ff;
   logic [7:0] out_char_ff;
   logic       out_header_ff;

   logic advance;
   logic out_free;

   assign csr_if.ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff  <= DELIMITER_RESET;
         has_header_ff <= 1'b0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_DELIMITER:  delimiter_ff  <= csr_if.data;
            CSR_HAS_HEADER: has_header_ff <= csr_if.data[0];
            default:        ;
         endcase
      end
   end

   cbt_step u_step (
      .state      (state_ff),
      .mode       (in_mode_ff),
      .char_value (in_char_ff),
      .delimiter  (delimiter_ff),
      .has_header (has_header_ff),
      .state_next (state_in),
      .event_out  (step_event)
   );

   // input stage moves on when its event (if any) has room
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign advance      = in_valid_ff && (!step_event.valid || out_free);
   assign req_if.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_mode_ff <= req_if.mode;
         in_char_ff <= req_if.char_value;
      end
   end

   // state update, once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TOK_STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && step_event.valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_event.valid) begin
         out_kind_ff   <= step_event.kind;
         out_char_ff   <= step_event.out_char;
         out_header_ff <= step_event.header_row;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.kind       = out_kind_ff;
   assign rsp_if.out_char   = out_char_ff;
   assign rsp_if.header_row = out_header_ff;

endmodule
